// ===== sv/dpswc_pkg.sv =====
// Shared types, widths and codes for the depth pixel wrist-cut pipeline.
package dpswc_pkg;

    // Field widths of the pixel stream and the register file.
    localparam int COL_W      = 10;
    localparam int ROW_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int DEPTH_W    = 16;
    localparam int PIX_W      = 12;
    localparam int K_W        = 32;
    localparam int BIAS_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Plane arithmetic widths.
    // Offset from the principal point: -4095 .. 1023.
    localparam int DIFF_W  = 13;
    // Coefficient times offset.
    localparam int PROD_W  = K_W + DIFF_W;
    // Sum of both products and kz.
    localparam int SUM_W   = PROD_W + 2;
    // Half of the depth word, one partial product each.
    localparam int HALF_W  = DEPTH_W / 2;
    localparam int PART_W  = SUM_W + HALF_W + 1;
    // Full plane distance; its magnitude stays below 2^62.
    localparam int DIST_W  = 64;

    // Pipeline stages that carry side data: decode plus four plane stages.
    localparam int SIDE_STAGES = 5;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_LIMIT = 3'd0,
        REG_PRINCIPAL_X = 3'd1,
        REG_PRINCIPAL_Y = 3'd2,
        REG_PLANE_KX    = 3'd3,
        REG_PLANE_KY    = 3'd4,
        REG_PLANE_KZ    = 3'd5,
        REG_PLANE_BIAS  = 3'd6
    } cfg_index_t;

    // Reset values of the registers.
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = 16'd1000;
    localparam logic [PIX_W-1:0]   PRINCIPAL_X_RST = 12'd320;
    localparam logic [PIX_W-1:0]   PRINCIPAL_Y_RST = 12'd240;

    // Result codes of one pixel.
    typedef enum logic [1:0] {
        ST_KEPT    = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_BEYOND  = 2'd2,
        ST_BEHIND  = 2'd3
    } pixel_status_t;

    // Wrist plane coefficients as held in the register file.
    typedef struct packed {
        logic signed [K_W-1:0]    kx;
        logic signed [K_W-1:0]    ky;
        logic signed [K_W-1:0]    kz;
        logic signed [BIAS_W-1:0] bias;
    } plane_cfg_t;

    // Per-pixel data that travels beside the plane arithmetic.
    typedef struct packed {
        logic [DEPTH_W-1:0] mval;
        logic [DEPTH_W-1:0] dval;
        pixel_status_t      status;
    } side_t;

endpackage

// ===== sv/dpswc_plane.sv =====
// Four-stage pipeline that tests a back-projected pixel against the wrist plane.
module dpswc_plane
    import dpswc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      en,
    input  plane_cfg_t                cfg,
    input  logic signed [DIFF_W-1:0]  du,
    input  logic signed [DIFF_W-1:0]  dv,
    input  logic        [DEPTH_W-1:0] d,
    output logic                      behind
);

    logic signed [PROD_W-1:0] kx_ext, ky_ext, du_ext, dv_ext;
    logic signed [PROD_W-1:0] px_next, py_next, px_reg, py_reg;
    logic [DEPTH_W-1:0]       d_a_reg, d_b_reg;
    logic signed [SUM_W-1:0]  sum_next, sum_reg;
    logic signed [PART_W-1:0] sum_ext, dhi_ext, dlo_ext;
    logic signed [PART_W-1:0] hi_next, lo_next, hi_reg, lo_reg;
    logic signed [DIST_W-1:0] hi_wide, lo_wide, bias_wide, plane_dist;
    logic                     behind_next, behind_reg;

    // Stage A: the x and y coefficients, each times its offset from the principal point.
    always_comb begin
        kx_ext  = {{(PROD_W-K_W){cfg.kx[K_W-1]}}, cfg.kx};
        ky_ext  = {{(PROD_W-K_W){cfg.ky[K_W-1]}}, cfg.ky};
        du_ext  = {{(PROD_W-DIFF_W){du[DIFF_W-1]}}, du};
        dv_ext  = {{(PROD_W-DIFF_W){dv[DIFF_W-1]}}, dv};
        px_next = kx_ext * du_ext;
        py_next = ky_ext * dv_ext;
    end

    // Stage B: add both products and the z coefficient.
    always_comb begin
        sum_next = {{(SUM_W-PROD_W){px_reg[PROD_W-1]}}, px_reg}
                 + {{(SUM_W-PROD_W){py_reg[PROD_W-1]}}, py_reg}
                 + {{(SUM_W-K_W){cfg.kz[K_W-1]}}, cfg.kz};
    end

    // Stage C: scale by the depth, one partial product per depth byte.
    always_comb begin
        sum_ext = {{(PART_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
        dhi_ext = {{(PART_W-HALF_W){1'b0}}, d_b_reg[DEPTH_W-1:HALF_W]};
        dlo_ext = {{(PART_W-HALF_W){1'b0}}, d_b_reg[HALF_W-1:0]};
        hi_next = sum_ext * dhi_ext;
        lo_next = sum_ext * dlo_ext;
    end

    // Stage D: merge the partial products, remove the bias and take the sign.
    always_comb begin
        hi_wide     = {{(DIST_W-PART_W){hi_reg[PART_W-1]}}, hi_reg};
        lo_wide     = {{(DIST_W-PART_W){lo_reg[PART_W-1]}}, lo_reg};
        bias_wide   = {{(DIST_W-BIAS_W){cfg.bias[BIAS_W-1]}}, cfg.bias};
        plane_dist  = (hi_wide <<< HALF_W) + lo_wide - bias_wide;
        behind_next = plane_dist[DIST_W-1];
    end

    // Stage registers; they hold while the pipeline is stalled.
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            d_a_reg    <= d;
            sum_reg    <= sum_next;
            d_b_reg    <= d_a_reg;
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
            behind_reg <= behind_next;
        end
    end

    assign behind = behind_reg;

endmodule

// ===== sv/depth_pixel_segment_wrist_cut_core.sv =====
// Top level of the depth pixel segmentation with wrist-plane cut.
//
// Usage: pixels enter on the s_ channel (valid/ready), one item per pixel
// with its column, row and the green and blue bytes of the mask and depth
// images. Each item gives exactly one result item on the m_ channel: the
// decoded mask value, the segmented depth and a status code.
// Registers are written through the cfg_ channel, which is always ready;
// write them only while no pixel is in flight.
// A result passes six register stages, the first loaded at the accepting edge:
// one decode stage, four plane stages (two multiply stages, one sum stage,
// one final add and sign), and the output register.
// Throughput is one item per clock while the receiver does not stall; the
// whole pipeline advances together.
// When the receiver stalls with a result waiting, every stage holds and
// s_ready drops in the same cycle, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// registers: depth limit 1000, principal point (320, 240), plane all zero.
module depth_pixel_segment_wrist_cut_core
    import dpswc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COL_W-1:0]      s_column,
    input  logic [ROW_W-1:0]      s_row,
    input  logic [BYTE_W-1:0]     s_mask_green,
    input  logic [BYTE_W-1:0]     s_mask_blue,
    input  logic [BYTE_W-1:0]     s_depth_green,
    input  logic [BYTE_W-1:0]     s_depth_blue,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DEPTH_W-1:0]    m_mask_depth,
    output logic [DEPTH_W-1:0]    m_depth_out,
    output logic [1:0]            m_pixel_status
);

    logic [DEPTH_W-1:0]       depth_limit_reg;
    logic [PIX_W-1:0]         principal_x_reg, principal_y_reg;
    plane_cfg_t               plane_reg;

    logic                     en;
    logic [SIDE_STAGES-1:0]   valid_reg;
    logic                     m_valid_reg;
    side_t                    side_next;
    side_t                    side_reg [SIDE_STAGES];
    logic signed [DIFF_W-1:0] du_next, dv_next, du_reg, dv_reg;
    logic                     behind;
    logic [DEPTH_W-1:0]       mask_out_next, depth_out_next;
    logic [DEPTH_W-1:0]       mask_out_reg, depth_out_reg;
    pixel_status_t            status_out_next, status_out_reg;

    // Register file; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_limit_reg <= DEPTH_LIMIT_RST;
            principal_x_reg <= PRINCIPAL_X_RST;
            principal_y_reg <= PRINCIPAL_Y_RST;
            plane_reg       <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEPTH_LIMIT: depth_limit_reg <= cfg_data[DEPTH_W-1:0];
                REG_PRINCIPAL_X: principal_x_reg <= cfg_data[PIX_W-1:0];
                REG_PRINCIPAL_Y: principal_y_reg <= cfg_data[PIX_W-1:0];
                REG_PLANE_KX:    plane_reg.kx    <= cfg_data[K_W-1:0];
                REG_PLANE_KY:    plane_reg.ky    <= cfg_data[K_W-1:0];
                REG_PLANE_KZ:    plane_reg.kz    <= cfg_data[K_W-1:0];
                REG_PLANE_BIAS:  plane_reg.bias  <= cfg_data[BIAS_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Decode stage: 16-bit values, early status and offsets from the principal point.
    always_comb begin
        side_next.mval = {s_mask_green, s_mask_blue};
        side_next.dval = {s_depth_green, s_depth_blue};
        if (side_next.mval == '0) begin
            side_next.status = ST_OUTSIDE;
        end else if (side_next.dval > depth_limit_reg) begin
            side_next.status = ST_BEYOND;
        end else begin
            side_next.status = ST_KEPT;
        end
        du_next = $signed({{(DIFF_W-COL_W){1'b0}}, s_column})
                - $signed({{(DIFF_W-PIX_W){1'b0}}, principal_x_reg});
        dv_next = $signed({{(DIFF_W-ROW_W){1'b0}}, s_row})
                - $signed({{(DIFF_W-PIX_W){1'b0}}, principal_y_reg});
    end

    // Valid bits travel with the data through every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg   <= {valid_reg[SIDE_STAGES-2:0], s_valid};
            m_valid_reg <= valid_reg[SIDE_STAGES-1];
        end
    end

    // Side data shift line, aligned with the plane stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            du_reg      <= du_next;
            dv_reg      <= dv_next;
            for (int i = 1; i < SIDE_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    dpswc_plane u_plane (
        .aclk   (aclk),
        .en     (en),
        .cfg    (plane_reg),
        .du     (du_reg),
        .dv     (dv_reg),
        .d      (side_reg[0].dval),
        .behind (behind)
    );

    // Final status: a kept pixel behind the wrist plane is cleared.
    always_comb begin
        mask_out_next   = side_reg[SIDE_STAGES-1].mval;
        depth_out_next  = '0;
        status_out_next = side_reg[SIDE_STAGES-1].status;
        if (side_reg[SIDE_STAGES-1].status == ST_KEPT) begin
            if (behind) begin
                status_out_next = ST_BEHIND;
            end else begin
                depth_out_next = side_reg[SIDE_STAGES-1].dval;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (en) begin
            mask_out_reg   <= mask_out_next;
            depth_out_reg  <= depth_out_next;
            status_out_reg <= status_out_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mask_depth   = mask_out_reg;
    assign m_depth_out    = depth_out_reg;
    assign m_pixel_status = status_out_reg;

    // A nonzero depth leaves only with a kept status.
    a_depth_only_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pixel_status == ST_KEPT || m_depth_out == '0))
        else $error("nonzero depth with a cleared status");

    // The outside-mask status matches a zero mask value.
    a_outside_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_mask_depth == '0) == (m_pixel_status == ST_OUTSIDE)))
        else $error("outside status does not match the mask value");

    // A stalled result freezes every stage's valid bit.
    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");

    // Reset empties the output register and every stage's valid bit.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && valid_reg == '0))
        else $error("pipeline not empty after reset");

endmodule
